/* hw/rtl/mgvf_pkg.sv */
// Package for the MGVF 3x3 stencil line buffer: sizes, register indexes,
// and the shared window type passed from the window cells to the datapath.
// No dependencies.
package mgvf_pkg;
	localparam int MaxCols  = 512;
	localparam int MaxRows  = 1023;
	localparam int FracBits = 16;
	localparam int ColW     = 10;
	localparam int MemAw    = 9;

	localparam logic [2:0] REG_MU  = 3'd0;
	localparam logic [2:0] REG_INV = 3'd1;
	localparam logic [2:0] REG_EPS = 3'd2;
	localparam logic [2:0] REG_COL = 3'd3;
	localparam logic [2:0] REG_ROW = 3'd4;

	// 3x3 neighborhood plus the centre image sample, with edge flags applied
	typedef struct packed {
		logic signed [31:0] ul, u, ur, l, c, r, dl, d, dr;
		logic signed [31:0] img;
		logic               eof;
	} win_t;
endpackage

/* hw/rtl/mgvf_cell.sv */
// One cell of the window chain: a 32-bit field or image tap that loads
// its input (neighbor or line memory) on each advance. Uses mgvf_pkg.
module mgvf_cell (
	input  logic               clk,
	input  logic               adv,
	input  logic signed [31:0] din,
	output logic signed [31:0] dout
);
	import mgvf_pkg::*;
	logic signed [31:0] val_q;
	always_ff @(posedge clk) begin
		if (adv) val_q <= din;
	end
	assign dout = val_q;
endmodule

/* hw/rtl/mgvf_calc.sv */
// Pipelined stencil arithmetic: Heaviside-weighted neighbor sum, vHe and
// image fidelity term, saturated to Q16.16. Uses mgvf_pkg.
module mgvf_calc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  mgvf_pkg::win_t      win,
	input  logic [16:0]         mu,
	input  logic [16:0]         inv,
	input  logic [15:0]         eps,
	output logic                out_vld,
	output logic signed [31:0]  out_val,
	output logic                out_eof
);
	import mgvf_pkg::*;

	function automatic logic signed [34:0] dterm(input logic signed [31:0] n,
		input logic signed [31:0] c, input logic [15:0] e);
		logic signed [33:0] x;
		logic signed [33:0] ee;
		begin
			x  = 34'(n) - 34'(c);
			ee = 34'($signed({1'b0, e}));
			if (x > ee) dterm = 35'(x) <<< 1;
			else if (x > -ee) dterm = 35'(x);
			else dterm = '0;
		end
	endfunction

	function automatic logic [63:0] rnd(input logic [63:0] m, input int sh);
		rnd = (m + (64'd1 << (sh - 1))) >> sh;
	endfunction

	// stage 1: sum
	logic signed [37:0] s2_s1;
	logic signed [31:0] c_s1, img_s1;
	logic eof_s1, v_s1;
	// stage 2: product
	logic [54:0] p_s2;
	logic neg_s2;
	logic signed [31:0] c_s2, img_s2;
	logic eof_s2, v_s2;
	// stage 3: vhe
	logic signed [31:0] vhe_s3, img_s3;
	logic eof_s3, v_s3;
	// stage 4: I*(vhe-I)
	logic [64:0] q_s4;
	logic neg4_s4;
	logic signed [31:0] vhe_s4;
	logic eof_s4, v_s4;
	// stage 5: saturated t1
	logic [47:0] t1m_s5;
	logic neg5_s5;
	logic signed [31:0] vhe_s5;
	logic eof_s5, v_s5;
	// stage 6: t1 * inv (upper/lower split)
	logic [64:0] pl_s6, ph_s6;
	logic neg6_s6;
	logic signed [31:0] vhe_s6;
	logic eof_s6, v_s6;

	logic signed [37:0] s2_c;
	logic [37:0] s2m;
	logic [63:0] r2;
	logic signed [39:0] vhe_w;
	logic signed [32:0] dv;
	logic [31:0] im, dm;
	logic [63:0] t1r;
	logic [63:0] t2r;
	logic [65:0] prod6;
	logic signed [49:0] fin;

	always_comb begin
		s2_c = 38'(dterm(win.ul, win.c, eps)) + 38'(dterm(win.u, win.c, eps))
			+ 38'(dterm(win.ur, win.c, eps)) + 38'(dterm(win.l, win.c, eps))
			+ 38'(dterm(win.r, win.c, eps)) + 38'(dterm(win.dl, win.c, eps))
			+ 38'(dterm(win.d, win.c, eps)) + 38'(dterm(win.dr, win.c, eps));
		s2m   = s2_s1[37] ? 38'(-s2_s1) : 38'(s2_s1);
		r2    = rnd(64'(p_s2), FracBits + 1);
		vhe_w = neg_s2 ? 40'(c_s2) - 40'(r2) : 40'(c_s2) + 40'(r2);
		dv    = 33'(vhe_s3) - 33'(img_s3);
		im    = img_s3[31] ? 32'(-33'(img_s3)) : 32'(img_s3);
		dm    = dv[32] ? 32'(-dv) : 32'(dv);
		t1r   = rnd(64'(q_s4), FracBits);
		prod6 = 66'(pl_s6) + (66'(ph_s6) << 24);
		t2r   = rnd(prod6[63:0], FracBits);
		fin   = neg6_s6 ? 50'(vhe_s6) + 50'(t2r) : 50'(vhe_s6) - 50'(t2r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_vld} <= '0;
		end else begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_vld}
				<= {in_vld, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6};
		end
	end

	always_ff @(posedge clk) begin
		s2_s1 <= s2_c; c_s1 <= win.c; img_s1 <= win.img; eof_s1 <= win.eof;
		p_s2 <= 55'(s2m) * 55'(mu); neg_s2 <= s2_s1[37];
		c_s2 <= c_s1; img_s2 <= img_s1; eof_s2 <= eof_s1;
		if (vhe_w > 40'sh7FFFFFFF) vhe_s3 <= 32'h7FFFFFFF;
		else if (vhe_w < -40'sh80000000) vhe_s3 <= 32'h80000000;
		else vhe_s3 <= 32'(vhe_w);
		img_s3 <= img_s2; eof_s3 <= eof_s2;
		q_s4 <= 65'(im) * 65'(dm);
		neg4_s4 <= (img_s3[31] != dv[32]) && (im != 0) && (dm != 0);
		vhe_s4 <= vhe_s3; eof_s4 <= eof_s3;
		// clamp magnitude to 2^47 (neg) or 2^47-1 (pos)
		if (neg4_s4 && t1r >= 64'h8000_0000_0000) t1m_s5 <= 48'h8000_0000_0000;
		else if (!neg4_s4 && t1r >= 64'h7FFF_FFFF_FFFF) t1m_s5 <= 48'h7FFF_FFFF_FFFF;
		else t1m_s5 <= 48'(t1r);
		neg5_s5 <= neg4_s4 && (t1r != 0);
		vhe_s5 <= vhe_s4; eof_s5 <= eof_s4;
		pl_s6 <= 65'(t1m_s5[23:0]) * 65'(inv);
		ph_s6 <= 65'(t1m_s5[47:24]) * 65'(inv);
		neg6_s6 <= neg5_s5; vhe_s6 <= vhe_s5; eof_s6 <= eof_s5;
		if (fin > 50'sh7FFFFFFF) out_val <= 32'h7FFFFFFF;
		else if (fin < -50'sh80000000) out_val <= 32'h80000000;
		else out_val <= 32'(fin);
		out_eof <= eof_s6;
	end
endmodule

/* hw/rtl/mgvf_stencil_line_buffer.sv */
// Top level of the MGVF 3x3 stencil line buffer: line memories, window
// cell chain, raster counters, result pipeline and output skid queue.
// Depends on mgvf_pkg, mgvf_cell and mgvf_calc.
//
// Usage: samples enter on s_axis in raster order, rows_in_use rows plus one
// halo row, tdata = {image_sample, field_sample}. Results leave on m_axis,
// tdata = flow_value, tlast = end_of_frame (last pixel of the partition).
// Output pixel (r-1,c-1) appears after sample (r,c) arrives; the last sample
// of each row after the first also yields the right-column pixel.
// A sample is accepted when the line memory read of its column has landed
// (read issued in the wait state, sample taken in the read state); after each
// accepted sample the block returns to the wait state, and a row's last sample
// that launches a second pixel first passes the second-result state. Results
// are registered through the launch register and mgvf_calc into the queue.
// The result queue holds 16 entries; s_tready drops while it cannot take
// the results still in flight, so a stalled receiver never loses data.
// Reset clears counters and restores register defaults; line memory contents
// are undefined until the first frame fills them. Configuration must be
// written on cfg_we/cfg_addr/cfg_data while idle; the block does not enforce it.
module mgvf_stencil_line_buffer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [16:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] field_sample, [63:32] image_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] flow_value
	output logic        m_axis_tlast    // end_of_frame
);
	import mgvf_pkg::*;

	logic [16:0] mu_q, inv_q;
	logic [15:0] eps_q;
	logic [ColW-1:0] cols_reg_q, rows_reg_q;
	logic [ColW-1:0] cols, rows;
	logic [ColW-1:0] col_q, row_q;
	logic [1:0] ph_q;        // 0 wait, 1 read issued, 2 second result
	localparam logic [1:0] PH_IDLE = 2'd0, PH_RD = 2'd1, PH_EXTRA = 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= 17'd6554; inv_q <= 17'd13107; eps_q <= 16'd7;
			cols_reg_q <= 10'd512; rows_reg_q <= 10'd1023;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MU:  mu_q <= cfg_data;
				REG_INV: inv_q <= cfg_data;
				REG_EPS: eps_q <= cfg_data[15:0];
				REG_COL: cols_reg_q <= cfg_data[ColW-1:0];
				REG_ROW: rows_reg_q <= cfg_data[ColW-1:0];
				default: ;
			endcase
		end
	end
	// 10-bit register caps at 1023 for rows; cols clamp to 2..MaxCols, rows to at least 1
	assign cols = (cols_reg_q < 10'd2) ? 10'd2 :
		((cols_reg_q > 10'(MaxCols)) ? 10'(MaxCols) : cols_reg_q);
	assign rows = (rows_reg_q < 10'd1) ? 10'd1 : rows_reg_q;

	// Line memories: per column, last two field rows and one image row.
	logic signed [31:0] fm1 [MaxCols];  // field row r-1
	logic signed [31:0] fm2 [MaxCols];  // field row r-2
	logic signed [31:0] im1 [MaxCols];  // image row r-1
	logic signed [31:0] fm1_rd, fm2_rd, im1_rd;

	logic acc, last;
	logic signed [31:0] fs, is_in;
	assign fs = s_axis_tdata[31:0];
	assign is_in = s_axis_tdata[63:32];
	assign last = col_q >= cols - 10'd1;

	logic [4:0] cnt_q;       // results in queue plus in flight
	logic room;
	assign room = cnt_q <= 5'd13;
	assign s_axis_tready = (ph_q == PH_RD) && room;
	assign acc = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk) begin
		fm1_rd <= fm1[col_q[MemAw-1:0]];
		fm2_rd <= fm2[col_q[MemAw-1:0]];
		im1_rd <= im1[col_q[MemAw-1:0]];
		if (acc) begin
			fm1[col_q[MemAw-1:0]] <= fs;
			fm2[col_q[MemAw-1:0]] <= fm1_rd;
			im1[col_q[MemAw-1:0]] <= is_in;
		end
	end

	// Window cell chain: three rows of three taps, shifted left on advance.
	logic signed [31:0] cd [3][3];  // [row: 0 up,1 mid,2 down][col: 0 left..2 right]
	logic signed [31:0] ci [2];     // image taps for middle row
	genvar gr, gc;
	generate
		for (gr = 0; gr < 3; gr++) begin : g_row
			for (gc = 0; gc < 3; gc++) begin : g_col
				logic signed [31:0] din;
				if (gc == 2) begin : g_new
					assign din = (gr == 0) ? fm2_rd : ((gr == 1) ? fm1_rd : fs);
				end else begin : g_sh
					assign din = cd[gr][gc+1];
				end
				mgvf_cell u_cell (.clk(clk), .adv(acc), .din(din), .dout(cd[gr][gc]));
			end
		end
		for (gc = 0; gc < 2; gc++) begin : g_img
			logic signed [31:0] din;
			if (gc == 1) begin : g_new
				assign din = im1_rd;
			end else begin : g_sh
				assign din = ci[1];
			end
			mgvf_cell u_icell (.clk(clk), .adv(acc), .din(din), .dout(ci[gc]));
		end
	endgenerate

	// Pixel launch: centre column 1 after advance; extra pixel centre column 2.
	logic launch_q, extra_q, top_q, left_q, eof_q;
	win_t win;
	always_comb begin
		logic signed [31:0] c;
		c = extra_q ? cd[1][2] : cd[1][1];
		win.c = c;
		win.img = extra_q ? ci[1] : ci[0];
		win.eof = eof_q && extra_q;
		if (extra_q) begin
			win.ul = top_q ? c : cd[0][1];
			win.u  = top_q ? c : cd[0][2];
			win.ur = c;
			win.l  = cd[1][1];
			win.r  = c;
			win.dl = cd[2][1];
			win.d  = cd[2][2];
			win.dr = c;
		end else begin
			win.ul = (top_q || left_q) ? c : cd[0][0];
			win.u  = top_q ? c : cd[0][1];
			win.ur = top_q ? c : cd[0][2];
			win.l  = left_q ? c : cd[1][0];
			win.r  = cd[1][2];
			win.dl = left_q ? c : cd[2][0];
			win.d  = cd[2][1];
			win.dr = cd[2][2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0; row_q <= '0; ph_q <= PH_IDLE;
			launch_q <= 1'b0; extra_q <= 1'b0;
		end else begin
			launch_q <= 1'b0; extra_q <= 1'b0;
			case (ph_q)
				PH_IDLE: ph_q <= PH_RD;      // issue memory read for col_q
				PH_RD: if (acc) begin
					launch_q <= (row_q >= 10'd1) && (last || col_q >= 10'd1);
					ph_q <= (row_q >= 10'd1 && last) ? PH_EXTRA : PH_IDLE;
					if (last) begin
						col_q <= '0;
						row_q <= (row_q >= rows) ? 10'd0 : row_q + 10'd1;
					end else begin
						col_q <= col_q + 10'd1;
					end
				end
				PH_EXTRA: begin
					extra_q <= 1'b1;
					ph_q <= PH_IDLE;
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end
	always_ff @(posedge clk) begin
		if (acc) begin
			top_q  <= row_q == 10'd1;
			left_q <= last ? (cols == 10'd2) : (col_q == 10'd1);
			eof_q  <= row_q == rows;
		end
	end

	logic cv;
	logic signed [31:0] cval;
	logic ceof;
	mgvf_calc u_calc (.clk(clk), .arst_n(arst_n), .in_vld(launch_q || extra_q),
		.win(win), .mu(mu_q), .inv(inv_q), .eps(eps_q),
		.out_vld(cv), .out_val(cval), .out_eof(ceof));

	// Result queue
	logic [32:0] fifo_q [16];
	logic [3:0] wp_q, rp_q;
	logic [4:0] qn_q;
	logic pop, ins;
	assign pop = m_axis_tvalid && m_axis_tready;
	assign ins = launch_q || extra_q;
	assign m_axis_tvalid = qn_q != 5'd0;
	assign {m_axis_tlast, m_axis_tdata} = fifo_q[rp_q];
	always_ff @(posedge clk) begin
		if (cv) fifo_q[wp_q] <= {ceof, cval};
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; qn_q <= '0; cnt_q <= '0;
		end else begin
			if (cv) wp_q <= wp_q + 4'd1;
			if (pop) rp_q <= rp_q + 4'd1;
			qn_q <= qn_q + 5'(cv) - 5'(pop);
			cnt_q <= cnt_q + 5'(ins) - 5'(pop);
		end
	end

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 5'd16)
		else $error("result count overflow");
	ap_q: assert property (@(posedge clk) disable iff (!arst_n) qn_q <= cnt_q)
		else $error("queue exceeds tracked results");
	ap_ex: assert property (@(posedge clk) disable iff (!arst_n) extra_q |-> !s_axis_tready)
		else $error("accept during extra pixel");
endmodule
